@@ hdl/itda_pkg.sv @@
`default_nettype none
package itda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int NUM_CELLS = 10;
  localparam int IDX_W     = 4;
  localparam int BIT_CNT_W = 5;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/itda_cell.sv @@
`default_nettype none
module itda_cell (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire itda_pkg::cell_ctrl_t         ctrl,
  input  wire                               bit_in,
  output logic                              bit_out,
  output logic [itda_pkg::DIGIT_W-1:0]      digit
);

  logic [itda_pkg::DIGIT_W-1:0] digit_r;
  logic [itda_pkg::DIGIT_W-1:0] digit_nxt;
  logic [itda_pkg::DIGIT_W-1:0] adj;

  // add-3 correction before the shift keeps the digit in BCD
  always_comb begin
    adj       = (digit_r >= itda_pkg::DIGIT_FIVE) ? digit_r + itda_pkg::DIGIT_ADJ : digit_r;
    bit_out   = adj[itda_pkg::DIGIT_W-1];
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[itda_pkg::DIGIT_W-2:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule
`default_nettype wire

@@ hdl/int_to_decimal_ascii.sv @@
`default_nettype none
// Signed 32-bit integer to decimal ASCII, most significant character first, with a
// leading '-' for negative values and out_last on the final character. The magnitude
// is shifted one bit per cycle into a row of ten BCD digit cells (shift-and-add-3); a
// number is accepted, its 32 bits are shifted in, the leading digit is found, and its
// 1 to 11 characters are then emitted one at a time. The next number is taken once
// the last character has been placed in the output register, while that character
// still awaits its transfer.
module int_to_decimal_ascii (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [itda_pkg::VALUE_W-1:0]    in_value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic       [itda_pkg::CHAR_W-1:0]     out_text_char,
  output logic                                  out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_LEAD = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [itda_pkg::VALUE_W-1:0]    mag_r, mag_nxt;
  logic                            neg_r, neg_nxt;
  logic [itda_pkg::BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [itda_pkg::IDX_W-1:0]      dig_idx_r, dig_idx_nxt;
  logic                            minus_pend_r, minus_pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [itda_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;

  itda_pkg::cell_ctrl_t            cell_ctrl;
  logic [itda_pkg::DIGIT_W-1:0]    digits [itda_pkg::NUM_CELLS];
  logic                            chain  [itda_pkg::NUM_CELLS+1];
  logic [itda_pkg::IDX_W-1:0]      lead_idx;
  logic                            in_xfer;
  logic                            load;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign load     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign cell_ctrl.clear = in_xfer;
  assign cell_ctrl.shift = (state_r == S_CONV);
  assign chain[0]        = mag_r[itda_pkg::VALUE_W-1];

  for (genvar g = 0; g < itda_pkg::NUM_CELLS; g++) begin : g_cell
    itda_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .bit_in  (chain[g]),
      .bit_out (chain[g+1]),
      .digit   (digits[g])
    );
  end

  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < itda_pkg::NUM_CELLS; i++) begin
      if (digits[i] != '0) lead_idx = itda_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    bit_cnt_nxt    = bit_cnt_r;
    dig_idx_nxt    = dig_idx_r;
    minus_pend_nxt = minus_pend_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt     = in_value[itda_pkg::VALUE_W-1];
          mag_nxt     = in_value[itda_pkg::VALUE_W-1] ? 32'(-in_value) : in_value;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        mag_nxt     = {mag_r[itda_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + itda_pkg::BIT_CNT_W'(1);
        if (bit_cnt_r == itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_W-1)) state_nxt = S_LEAD;
      end
      S_LEAD: begin
        dig_idx_nxt    = lead_idx;
        minus_pend_nxt = neg_r;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (minus_pend_r) begin
            out_char_nxt   = itda_pkg::CHAR_MINUS;
            out_last_nxt   = 1'b0;
            minus_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = itda_pkg::CHAR_ZERO + {4'b0000, digits[dig_idx_r]};
            out_last_nxt = (dig_idx_r == '0);
            dig_idx_nxt  = dig_idx_r - itda_pkg::IDX_W'(1);
            if (dig_idx_r == '0) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      minus_pend_r <= 1'b0;
      bit_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      minus_pend_r <= minus_pend_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    dig_idx_r  <= dig_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> !chain[itda_pkg::NUM_CELLS])
    else $error("BCD row overflow");

  a_lead_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEAD) |-> ($past(state_r) == S_CONV) &&
      ($past(bit_cnt_r) == itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_W-1)))
    else $error("leading digit search entered early");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (dig_idx_r < itda_pkg::IDX_W'(itda_pkg::NUM_CELLS)))
    else $error("digit index out of range");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && minus_pend_r) |=> (out_text_char == itda_pkg::CHAR_MINUS) && !out_last)
    else $error("sign character malformed");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_text_char != itda_pkg::CHAR_MINUS))
    else $error("sign flagged as last character");

endmodule
`default_nettype wire

@@ bench/int_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps
module int_to_decimal_ascii_tb;

  localparam int N_DIRECTED  = 18;
  localparam int N_RANDOM    = 320;
  localparam int N_CALM      = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [itda_pkg::VALUE_W-1:0] DEC_BASE = 32'd10;

  typedef struct packed {
    logic [itda_pkg::CHAR_W-1:0] text_char;
    logic                        last;
  } char_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [itda_pkg::VALUE_W-1:0] in_value = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [itda_pkg::CHAR_W-1:0] out_text_char;
  logic out_last;

  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   err_count = 0;
  char_beat_t expected_text[$];

  // rows with text given are checked against that text, the rest against the predictor
  logic [itda_pkg::VALUE_W-1:0] directed_value [N_DIRECTED] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, 32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd99, 32'd100, 32'h0000_FFFF, 32'hFFFF_FF9C
  };
  string directed_text [N_DIRECTED] = '{
    "0", "1", "-1", "9", "10", "-10",
    "2147483647", "-2147483648", "", "1000000000",
    "", "", "", "",
    "", "", "", ""
  };

  int_to_decimal_ascii uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_decimal_text(input logic [itda_pkg::VALUE_W-1:0] value);
    logic [itda_pkg::VALUE_W-1:0] mag;
    logic [itda_pkg::DIGIT_W-1:0] digits[$];
    logic negative;
    negative = value[itda_pkg::VALUE_W-1];
    mag = negative ? (32'd0 - value) : value;
    do begin
      digits.push_front(itda_pkg::DIGIT_W'(mag % DEC_BASE));
      mag = mag / DEC_BASE;
    end while (mag != 0);
    if (negative) expected_text.push_back('{itda_pkg::CHAR_MINUS, 1'b0});
    foreach (digits[k])
      expected_text.push_back('{itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digits[k]),
                                k == digits.size() - 1});
  endfunction

  function automatic void push_typed_text(input string text);
    for (int k = 0; k < text.len(); k++)
      expected_text.push_back('{itda_pkg::CHAR_W'(text[k]), k == text.len() - 1});
  endfunction

  function automatic logic [itda_pkg::VALUE_W-1:0] random_value();
    logic [itda_pkg::VALUE_W-1:0] v;
    longint unsigned span;
    span = 1;
    repeat ($urandom_range(1, 9)) span = span * DEC_BASE;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(32'(span - 1), 32'(span / DEC_BASE));
      2: v = 32'(span) + $urandom_range(0, 2) - 32'd1;
      default: v = $urandom_range(0, 20);
    endcase
    if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  task automatic convert_value(input logic [itda_pkg::VALUE_W-1:0] value, input string text);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text.len() != 0) push_typed_text(text);
    else predict_decimal_text(value);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      convert_value(directed_value[i], directed_text[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_on <= (i < N_RANDOM - N_CALM) && ((i / 40) % 3 != 2);
      convert_value(random_value(), "");
    end
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        $error("text_char: no transfer expected, actual %h", out_text_char);
        err_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_text_char !== want.text_char) begin
          $error("text_char: expected %h, actual %h", want.text_char, out_text_char);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
